/* hdl/hcbd_pkg.sv */
package hcbd_pkg;

    localparam int SIZE_LINE_MAX_DEF    = 15;
    localparam int TRAILER_LINE_MAX_DEF = 3;

    localparam int CHUNK_W = 31;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    localparam logic [1:0] PH_SIZE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    localparam logic [2:0] ST_LEAD   = 3'd0;
    localparam logic [2:0] ST_SIGN   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_PREFIX = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;
    localparam logic [2:0] ST_STOP   = 3'd5;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
    } hcbd_in_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       body_done;
    } hcbd_out_t;

    typedef struct packed {
        logic [2:0]         stage;
        logic               negative;
        logic [CHUNK_W-1:0] value;
    } hcbd_num_t;

endpackage

/* hdl/hcbd_size_parser.sv */
module hcbd_size_parser import hcbd_pkg::*;
(
    input  hcbd_num_t  num,
    input  logic [7:0] char_in,
    output hcbd_num_t  num_next
);

    logic       is_hex;
    logic [3:0] digit;
    logic       is_space;
    logic       is_sign;
    hcbd_num_t  added;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (char_in >= "0" && char_in <= "9")
        begin
            digit = 4'(char_in - "0");
        end
        else if (char_in >= "a" && char_in <= "f")
        begin
            digit = 4'(char_in - "a" + 8'd10);
        end
        else if (char_in >= "A" && char_in <= "F")
        begin
            digit = 4'(char_in - "A" + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign is_space = (char_in == " ") || (char_in == 8'h09) ||
                      (char_in == 8'h0B) || (char_in == 8'h0C);
    assign is_sign  = (char_in == "+") || (char_in == "-");

    // The magnitude saturates once any of the top four bits would shift out.
    always_comb
    begin
        added       = num;
        added.stage = ST_DIGITS;
        if (|num.value[CHUNK_W-1:CHUNK_W-4])
        begin
            added.value = {CHUNK_W{1'b1}};
        end
        else
        begin
            added.value = {num.value[CHUNK_W-5:0], digit};
        end
    end

    always_comb
    begin
        num_next = num;
        unique case (num.stage) inside
            ST_LEAD:
            begin
                if (is_space)
                begin
                    num_next = num;
                end
                else if (is_sign)
                begin
                    num_next.negative = (char_in == "-");
                    num_next.stage    = ST_SIGN;
                end
                else if (char_in == "0")
                begin
                    num_next.stage = ST_ZERO;
                end
                else if (is_hex)
                begin
                    num_next = added;
                end
                else
                begin
                    num_next.stage = ST_STOP;
                end
            end
            ST_SIGN:
            begin
                if (char_in == "0")
                begin
                    num_next.stage = ST_ZERO;
                end
                else if (is_hex)
                begin
                    num_next = added;
                end
                else
                begin
                    num_next.stage = ST_STOP;
                end
            end
            ST_ZERO:
            begin
                if (char_in == "x" || char_in == "X")
                begin
                    num_next.stage = ST_PREFIX;
                end
                else if (is_hex)
                begin
                    num_next = added;
                end
                else
                begin
                    num_next.stage = ST_STOP;
                end
            end
            ST_PREFIX, ST_DIGITS:
            begin
                if (is_hex)
                begin
                    num_next = added;
                end
                else
                begin
                    num_next.stage = ST_STOP;
                end
            end
            default:
            begin
                num_next.stage = ST_STOP;
            end
        endcase
    end

endmodule

/* hdl/http_chunked_body_decoder_core.sv */
// HTTP/1.1 body decoder. Raw body words enter on in_valid/in_ready with a
// command (body byte, read timeout, start of body) and decoded results leave
// on out_valid/out_ready, each either one payload byte or one end-of-body mark.
// With chunked_mode clear every byte passes through unless the body has finished; with it set the chunk
// size lines and trailers are consumed and only chunk data comes out.
// The chunked_mode register is written through cfg_wr_en/cfg_wr_data and
// should only change while the block is idle.
// Each accepted word updates the decoder state in the cycle it is taken, and
// its result, if any, appears on the output register in the following cycle.
// A new word is accepted every cycle as long as the output register is empty
// or is being drained in the same cycle, so throughput is one word per cycle.
// When the receiver stalls with a result pending, in_ready drops until the
// result is taken; words that produce no result still need that slot free.
// Reset clears the decoder to the start of a body, empties the output
// register and clears chunked_mode.
module http_chunked_body_decoder_core import hcbd_pkg::*;
#(
    parameter int SIZE_LINE_MAX    = SIZE_LINE_MAX_DEF,
    parameter int TRAILER_LINE_MAX = TRAILER_LINE_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  hcbd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hcbd_out_t out_data
);

    localparam int LINE_MAX = (SIZE_LINE_MAX > TRAILER_LINE_MAX) ?
                              SIZE_LINE_MAX : TRAILER_LINE_MAX;
    localparam int LC_W     = $clog2(LINE_MAX + 1);

    logic               chunked_mode_reg;
    logic [1:0]         phase_reg,      phase_next;
    hcbd_num_t          num_reg,        num_next;
    logic [LC_W-1:0]    line_chars_reg, line_chars_next;
    logic               finished_reg,   finished_next;
    logic               out_valid_reg,  out_valid_next;
    hcbd_out_t          out_reg,        out_next;

    hcbd_num_t          parsed;
    logic [LC_W-1:0]    lc_inc;
    logic               accept;
    logic               load;

    hcbd_size_parser u_parser
    (
        .num      (num_reg),
        .char_in  (in_data.in_byte),
        .num_next (parsed)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign lc_inc   = line_chars_reg + 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        num_next        = num_reg;
        line_chars_next = line_chars_reg;
        finished_next   = finished_reg;
        load            = 1'b0;
        out_next        = '{payload_valid: 1'b1, payload_byte: in_data.in_byte,
                            body_done: 1'b0};

        if (accept)
        begin
            if (in_data.cmd == CMD_START)
            begin
                phase_next      = PH_SIZE;
                num_next        = '{stage: ST_LEAD, negative: 1'b0, value: '0};
                line_chars_next = '0;
                finished_next   = 1'b0;
            end
            else if (in_data.cmd != CMD_BYTE && in_data.cmd != CMD_TIMEOUT)
            begin
                load = 1'b0;
            end
            else if (finished_reg)
            begin
                load = 1'b0;
            end
            else if (!chunked_mode_reg)
            begin
                load = (in_data.cmd == CMD_BYTE);
            end
            else if (phase_reg == PH_DATA)
            begin
                if (in_data.cmd == CMD_BYTE)
                begin
                    load = 1'b1;
                    if (num_reg.value != '0)
                    begin
                        num_next.value = num_reg.value - 1'b1;
                    end
                    if (num_reg.value <= CHUNK_W'(1))
                    begin
                        phase_next      = PH_TRAIL;
                        line_chars_next = '0;
                    end
                end
            end
            else if (phase_reg == PH_TRAIL)
            begin
                if (in_data.cmd == CMD_TIMEOUT || in_data.in_byte == CHAR_LF ||
                    (in_data.in_byte != CHAR_CR &&
                     lc_inc >= LC_W'(TRAILER_LINE_MAX)))
                begin
                    phase_next      = PH_SIZE;
                    line_chars_next = '0;
                    num_next        = '{stage: ST_LEAD, negative: 1'b0, value: '0};
                end
                else if (in_data.in_byte != CHAR_CR)
                begin
                    line_chars_next = lc_inc;
                end
            end
            else
            begin
                phase_next = PH_SIZE;
                if (in_data.cmd == CMD_TIMEOUT)
                begin
                    finished_next = 1'b1;
                    load          = 1'b1;
                    out_next      = '{payload_valid: 1'b0, payload_byte: 8'd0,
                                      body_done: 1'b1};
                end
                else if (in_data.in_byte != CHAR_CR)
                begin
                    if (in_data.in_byte != CHAR_LF)
                    begin
                        num_next        = parsed;
                        line_chars_next = lc_inc;
                    end
                    // The line closes at a line feed or when it is full.
                    if (in_data.in_byte == CHAR_LF ||
                        lc_inc >= LC_W'(SIZE_LINE_MAX))
                    begin
                        line_chars_next = '0;
                        num_next.stage  = ST_LEAD;
                        if (num_next.negative || num_next.value == '0)
                        begin
                            finished_next = 1'b1;
                            load          = 1'b1;
                            out_next      = '{payload_valid: 1'b0,
                                              payload_byte: 8'd0,
                                              body_done: 1'b1};
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunked_mode_reg <= 1'b0;
            phase_reg        <= PH_SIZE;
            num_reg          <= '{stage: ST_LEAD, negative: 1'b0, value: '0};
            line_chars_reg   <= '0;
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                chunked_mode_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            num_reg        <= num_next;
            line_chars_reg <= line_chars_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({out_data.payload_valid, out_data.body_done}))
        else $error("result carries both or neither of payload and done");

    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(finished_reg) |-> (out_valid && out_data.body_done))
        else $error("body ended without a done result");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (num_reg.value != '0))
        else $error("chunk data phase with no bytes left");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");
`endif

endmodule

/* tb/hcbd_checker.sv */
`timescale 1ns / 1ps

module hcbd_checker import hcbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      in_valid,
    input  logic      in_ready,
    input  hcbd_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  hcbd_out_t out_data,
    output int        mismatch_count,
    output int        results_pending
);

    localparam longint SIZE_CEILING = 64'h7FFF_FFFF;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;

    hcbd_out_t results_due[$];

    logic               chunked_on;
    logic [1:0]         body_phase;
    logic [CHUNK_W-1:0] chunk_left;
    int                 line_chars;
    logic [2:0]         size_stage;
    logic               size_negative;
    logic               body_finished;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void restart_size_line();
        body_phase    = PH_SIZE;
        chunk_left    = '0;
        line_chars    = 0;
        size_stage    = ST_LEAD;
        size_negative = 1'b0;
    endfunction

    function automatic void take_digit(input int d);
        longint v;
        v = (longint'(chunk_left) << 4) + longint'(d);
        if (v > SIZE_CEILING)
        begin
            v = SIZE_CEILING;
        end
        chunk_left = v[CHUNK_W-1:0];
        size_stage = ST_DIGITS;
    endfunction

    function automatic void parse_size_char(input logic [7:0] c);
        int d;
        d = hex_digit(c);
        if (size_stage == ST_LEAD)
        begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)
            begin
                return;
            end
            if (c == "+" || c == "-")
            begin
                size_negative = (c == "-");
                size_stage    = ST_SIGN;
                return;
            end
        end
        case (size_stage)
            ST_LEAD, ST_SIGN:
            begin
                if (c == "0")
                begin
                    size_stage = ST_ZERO;
                end
                else if (d >= 0)
                begin
                    take_digit(d);
                end
                else
                begin
                    size_stage = ST_STOP;
                end
            end
            ST_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    size_stage = ST_PREFIX;
                end
                else if (d >= 0)
                begin
                    take_digit(d);
                end
                else
                begin
                    size_stage = ST_STOP;
                end
            end
            ST_PREFIX, ST_DIGITS:
            begin
                if (d >= 0)
                begin
                    take_digit(d);
                end
                else
                begin
                    size_stage = ST_STOP;
                end
            end
            default:
            begin
                size_stage = ST_STOP;
            end
        endcase
    endfunction

    function automatic bit close_size_line(output hcbd_out_t r);
        r          = '0;
        line_chars = 0;
        size_stage = ST_LEAD;
        if (size_negative || chunk_left == '0)
        begin
            body_finished = 1'b1;
            r.body_done   = 1'b1;
            return 1'b1;
        end
        body_phase = PH_DATA;
        return 1'b0;
    endfunction

    // Returns 1 when the word produces a result, which is then placed in r.
    function automatic bit decode_word(input hcbd_in_t w, output hcbd_out_t r);
        r = '0;
        if (w.cmd == CMD_START)
        begin
            restart_size_line();
            body_finished = 1'b0;
            return 1'b0;
        end
        if ((w.cmd != CMD_BYTE && w.cmd != CMD_TIMEOUT) || body_finished)
        begin
            return 1'b0;
        end
        if (!chunked_on)
        begin
            if (w.cmd != CMD_BYTE)
            begin
                return 1'b0;
            end
            r.payload_valid = 1'b1;
            r.payload_byte  = w.in_byte;
            return 1'b1;
        end
        if (body_phase == PH_DATA)
        begin
            if (w.cmd != CMD_BYTE)
            begin
                return 1'b0;
            end
            if (chunk_left != '0)
            begin
                chunk_left = chunk_left - 1'b1;
            end
            if (chunk_left == '0)
            begin
                body_phase = PH_TRAIL;
                line_chars = 0;
            end
            r.payload_valid = 1'b1;
            r.payload_byte  = w.in_byte;
            return 1'b1;
        end
        if (body_phase == PH_TRAIL)
        begin
            if (w.cmd == CMD_TIMEOUT || w.in_byte == CHAR_LF)
            begin
                restart_size_line();
                return 1'b0;
            end
            if (w.in_byte == CHAR_CR)
            begin
                return 1'b0;
            end
            line_chars++;
            if (line_chars >= TRAILER_LINE_MAX_DEF)
            begin
                restart_size_line();
            end
            return 1'b0;
        end
        body_phase = PH_SIZE;
        if (w.cmd == CMD_TIMEOUT)
        begin
            body_finished = 1'b1;
            r.body_done   = 1'b1;
            return 1'b1;
        end
        if (w.in_byte == CHAR_LF)
        begin
            return close_size_line(r);
        end
        if (w.in_byte == CHAR_CR)
        begin
            return 1'b0;
        end
        parse_size_char(w.in_byte);
        line_chars++;
        if (line_chars >= SIZE_LINE_MAX_DEF)
        begin
            return close_size_line(r);
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] expected,
                                        input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hcbd_out_t due;
        if (!rst_n)
        begin
            chunked_on    = 1'b0;
            body_finished = 1'b0;
            restart_size_line();
            results_due.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                chunked_on = cfg_wr_data;
            end
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: payload_valid %0b payload_byte 0x%02h body_done %0b",
                           out_data.payload_valid, out_data.payload_byte, out_data.body_done);
                    mismatch_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("payload_valid", 8'(due.payload_valid), 8'(out_data.payload_valid));
                    check_field("payload_byte", due.payload_byte, out_data.payload_byte);
                    check_field("body_done", 8'(due.body_done), 8'(out_data.body_done));
                end
            end
            if (in_valid && in_ready)
            begin
                if (decode_word(in_data, due))
                begin
                    results_due.push_back(due);
                end
            end
            results_pending = results_due.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hcbd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = CMD_START | CMD_TIMEOUT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WORDS_PER_PHASE = 24;

    logic      clk;
    logic      rst_n;
    logic      cfg_wr_en;
    logic      cfg_wr_data;
    logic      in_valid;
    logic      in_ready;
    hcbd_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    hcbd_out_t out_data;

    int mismatch_count;
    int results_pending;
    int cycles;
    int words_sent;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    http_chunked_body_decoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    hcbd_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles > CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        in_data.cmd     = cmd;
        in_data.in_byte = b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(CMD_BYTE, s[i]);
        end
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (results_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic chunked);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = chunked;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_size_line(input int size);
        string      line;
        string      digits;
        logic [7:0] blank;
        line = "";
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       blank = " ";
                1:       blank = 8'h09;
                2:       blank = 8'h0B;
                default: blank = 8'h0C;
            endcase
            line = $sformatf("%s%c", line, blank);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            line = {line, "+"};
        end
        case ($urandom_range(0, 3))
            0:       line = {line, "0x"};
            1:       line = {line, "0X"};
            2:       line = {line, "0"};
            default: ;
        endcase
        digits = $sformatf("%0h", size);
        if ($urandom_range(0, 1) == 1)
        begin
            digits = digits.toupper();
        end
        line = {line, digits};
        if ($urandom_range(0, 5) == 0)
        begin
            line = {line, ";e"};
        end
        if ($urandom_range(0, 3) != 0)
        begin
            line = {line, "\r"};
        end
        line = {line, "\n"};
        send_text(line);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(2, 8))
        begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_chunked_body();
        int size;
        if ($urandom_range(0, 7) == 0)
        begin
            send_noise();
        end
        send_word(CMD_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 11) == 0)
        begin
            // A saturated size ends at the next start; a negative one ends the body.
            if ($urandom_range(0, 1) == 1)
            begin
                send_text("7fffffffff\n");
            end
            else
            begin
                send_text("-FFFFFFFFF0\r\n");
            end
            repeat ($urandom_range(1, 6))
            begin
                send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            return;
        end
        repeat ($urandom_range(1, 4))
        begin
            size = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 24);
            send_size_line(size);
            repeat (size)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
                end
                send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0:       send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
                1:       send_text("\n");
                2:       send_text("x\r\n");
                3:       send_text("ab\n");
                4:       send_text("abc");
                default: send_text("\r\n");
            endcase
        end
        case ($urandom_range(0, 6))
            0:       send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
            1:       send_text("-3\n");
            2:       send_text(" 0x0\r\n");
            3:       send_text("000000000000000");
            4:       send_text("g\n");
            default: send_text("0\r\n");
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                send_word(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_raw_words(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int target;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        words_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_TIMEOUT, 8'h55);
        send_word(CMD_UNUSED, 8'hAA);

        write_mode(1'b1);
        send_word(CMD_START, 8'h00);
        send_text("\t1\r\n");
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_TIMEOUT, 8'h00);
        send_text("x\n");
        send_word(CMD_BYTE, "A");
        send_word(CMD_TIMEOUT, 8'h00);
        send_word(CMD_UNUSED, 8'h0F);
        send_word(CMD_START, 8'hF0);
        send_word(CMD_TIMEOUT, 8'h00);
        send_word(CMD_START, 8'h00);
        send_text("-1\n");
        send_word(CMD_START, 8'h00);
        send_text("1\n");
        send_word(CMD_TIMEOUT, 8'h00);
        send_word(CMD_BYTE, CHAR_LF);
        send_text("\n0\n");

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default:
                begin
                    send_idle_pct = 9;
                    stall_pct     = 9;
                end
            endcase
            write_mode(1'b1);
            target = words_sent + (WORDS_PER_PHASE * 3) / 4;
            while (words_sent < target)
            begin
                send_chunked_body();
            end
            write_mode(1'b0);
            send_raw_words(WORDS_PER_PHASE / 4);
        end

        settle();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 300;
        send_raw_words(60);

        write_mode(1'b1);
        send_word(CMD_START, 8'h00);
        send_text("2\r\n");
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_text("\r\n0\r\n");

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
